### hdl/periodic_task_slot_scheduler_defines.svh
// ---------------------------------------------------------------------------
// periodic task slot scheduler: assertion macros
// shared checks written as clocked implications with reset disable
// ---------------------------------------------------------------------------
`ifndef PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_SLOT_SCHEDULER_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define PTSS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ptss assertion failed");

// next-cycle implication, disabled while reset is low
`define PTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ptss assertion failed");

`endif

### hdl/ptss_pkg.sv
// ---------------------------------------------------------------------------
// ptss_pkg
// request and status codes of the periodic task slot scheduler
// ---------------------------------------------------------------------------
`default_nettype none

package ptss_pkg;

  // request codes carried by in_req_type
  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_ADD      = 3'd1,
    REQ_DELETE   = 3'd2,
    REQ_DISPATCH = 3'd3,
    REQ_QUERY    = 3'd4
  } req_t;

  // status codes carried by out_status
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_BAD   = 2'd3
  } status_t;

endpackage

`default_nettype wire

### hdl/ptss_ram.sv
// ---------------------------------------------------------------------------
// ptss_ram
// generic simple dual-port ram, one write and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module ptss_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

### hdl/periodic_task_slot_scheduler.sv
// ---------------------------------------------------------------------------
// periodic_task_slot_scheduler
// table of periodic task slots with tick, add, delete, dispatch and query
// ---------------------------------------------------------------------------
// A request is transferred on a rising edge with start high and busy low.
// Results come back on the out_ ports, each valid for one cycle while
// out_strobe is high; out_last marks the final result of a request.
// Add, delete, query and unknown requests give one result in the cycle
// after the transfer and leave busy low, so such a request can be taken
// every cycle.
// Tick and dispatch walk the slot memory one slot a cycle through its
// single read port, with each slot handled in the cycle after its read (a
// tick writes it back); busy stays high for the whole walk. The tick result
// comes once the last slot is handled; dispatch gives one result per
// pending slot, in slot order. A dispatch with nothing pending answers in
// the next cycle.
// Handles, counters and periods live in the memory; valid and pending
// marks are flip-flops. Reset clears the marks at once, so there is no
// clearing pass and a request can be taken in the first cycle after reset.
// The receiver cannot stall: every result is shown for exactly one cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "periodic_task_slot_scheduler_defines.svh"

module periodic_task_slot_scheduler
  import ptss_pkg::*;
#(
  parameter int NUM_SLOTS  = 8,
  parameter int COUNT_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_req_type,
  input  wire logic [7:0]  in_task_handle,
  input  wire logic [15:0] in_first_delay,
  input  wire logic [15:0] in_reload_period,
  input  wire logic [3:0]  in_slot_index,
  output logic             out_strobe,
  output logic [3:0]       out_slot_number,
  output logic [1:0]       out_status,
  output logic [7:0]       out_handle_out,
  output logic             out_pending_out,
  output logic             out_last
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);
  localparam int ENT_W = 8 + 2 * COUNT_BITS;
  localparam logic [3:0]       SLOT_NONE = 4'(NUM_SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_SLOTS - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_TICK = 3'b010,
    ST_DISP = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_SLOTS-1:0] valid_r, valid_nxt;
  logic [NUM_SLOTS-1:0] pending_r, pending_nxt;
  logic [CNT_W-1:0]     iss_cnt_r, iss_cnt_nxt;
  logic                 wb_vld_r, wb_vld_nxt;
  logic [IDX_W-1:0]     wb_idx_r, wb_idx_nxt;

  logic                 strobe_r, strobe_nxt;
  logic [3:0]           slot_r, slot_nxt;
  logic [1:0]           status_r, status_nxt;
  logic [7:0]           handle_r, handle_nxt;
  logic                 pend_r, pend_nxt;
  logic                 last_r, last_nxt;

  // memory ports
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_addr;
  logic [ENT_W-1:0]     wr_data;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [ENT_W-1:0]     rd_data;

  logic                 accept;
  logic                 free_found;
  logic [IDX_W-1:0]     free_idx;
  logic                 idx_bad;
  logic [IDX_W-1:0]     idx_lo;
  logic [31:0]          delay_ext;
  logic [31:0]          period_ext;
  logic [COUNT_BITS-1:0] ent_cnt;
  logic [COUNT_BITS-1:0] ent_rel;
  logic [7:0]           ent_handle;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [NUM_SLOTS-1:0] pend_rest;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  assign idx_bad    = ({1'b0, in_slot_index} >= 5'(NUM_SLOTS));
  assign idx_lo     = in_slot_index[IDX_W-1:0];
  assign delay_ext  = {16'd0, in_first_delay};
  assign period_ext = {16'd0, in_reload_period};

  // fields of the entry read back from memory
  assign ent_handle = rd_data[ENT_W-1 -: 8];
  assign ent_cnt    = rd_data[2*COUNT_BITS-1 -: COUNT_BITS];
  assign ent_rel    = rd_data[COUNT_BITS-1:0];
  assign cnt_dec    = (ent_cnt != '0) ? ent_cnt - COUNT_BITS'(1) : ent_cnt;
  assign pend_rest  = pending_r & ~(NUM_SLOTS'(1) << wb_idx_r);

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // request decode, slot walk and result generation
  always_comb begin
    state_nxt   = state_r;
    valid_nxt   = valid_r;
    pending_nxt = pending_r;
    iss_cnt_nxt = iss_cnt_r;
    wb_vld_nxt  = 1'b0;
    wb_idx_nxt  = wb_idx_r;
    strobe_nxt  = 1'b0;
    slot_nxt    = SLOT_NONE;
    status_nxt  = STAT_OK;
    handle_nxt  = '0;
    pend_nxt    = 1'b0;
    last_nxt    = 1'b1;
    wr_en       = 1'b0;
    wr_addr     = wb_idx_r;
    wr_data     = '0;
    rd_en       = 1'b0;
    rd_addr     = iss_cnt_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        iss_cnt_nxt = '0;
        if (accept) begin
          strobe_nxt = 1'b1;
          unique case (req_t'(in_req_type))
            REQ_TICK: begin
              strobe_nxt = 1'b0;
              state_nxt  = ST_TICK;
            end
            REQ_ADD: begin
              if (free_found) begin
                valid_nxt[free_idx]   = 1'b1;
                pending_nxt[free_idx] = 1'b0;
                wr_en    = 1'b1;
                wr_addr  = free_idx;
                wr_data  = {in_task_handle, delay_ext[COUNT_BITS-1:0],
                            period_ext[COUNT_BITS-1:0]};
                slot_nxt = 4'(free_idx);
              end else begin
                status_nxt = STAT_FULL;
              end
            end
            REQ_DELETE: begin
              if (idx_bad) begin
                status_nxt = STAT_BAD;
              end else begin
                valid_nxt[idx_lo]   = 1'b0;
                pending_nxt[idx_lo] = 1'b0;
                slot_nxt = in_slot_index;
              end
            end
            REQ_DISPATCH: begin
              if (pending_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                strobe_nxt = 1'b0;
                state_nxt  = ST_DISP;
              end
            end
            REQ_QUERY: begin
              if (idx_bad) begin
                status_nxt = STAT_BAD;
              end else begin
                slot_nxt = in_slot_index;
                pend_nxt = pending_r[idx_lo];
              end
            end
            default: begin
              // unknown request: tick-like result, no change
            end
          endcase
        end
      end

      ST_TICK: begin
        // issue the next read
        if (iss_cnt_r < CNT_W'(NUM_SLOTS)) begin
          rd_en       = 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_idx_nxt  = iss_cnt_r[IDX_W-1:0];
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        end
        // count down and reload the slot read last cycle
        if (wb_vld_r) begin
          if (valid_r[wb_idx_r]) begin
            wr_en = 1'b1;
            if (cnt_dec == '0) begin
              pending_nxt[wb_idx_r] = 1'b1;
              wr_data = {ent_handle, ent_rel, ent_rel};
            end else begin
              wr_data = {ent_handle, cnt_dec, ent_rel};
            end
          end
          if (wb_idx_r == LAST_IDX) begin
            strobe_nxt = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end
      end

      ST_DISP: begin
        if (iss_cnt_r < CNT_W'(NUM_SLOTS)) begin
          rd_en       = 1'b1;
          wb_vld_nxt  = 1'b1;
          wb_idx_nxt  = iss_cnt_r[IDX_W-1:0];
          iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        end
        // report a pending slot and clear its flag
        if (wb_vld_r) begin
          if (pending_r[wb_idx_r]) begin
            pending_nxt[wb_idx_r] = 1'b0;
            strobe_nxt = 1'b1;
            slot_nxt   = 4'(wb_idx_r);
            handle_nxt = ent_handle;
            last_nxt   = (pend_rest == '0);
          end
          if (wb_idx_r == LAST_IDX) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      valid_r   <= '0;
      pending_r <= '0;
      iss_cnt_r <= '0;
      wb_vld_r  <= 1'b0;
      strobe_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      valid_r   <= valid_nxt;
      pending_r <= pending_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      wb_vld_r  <= wb_vld_nxt;
      strobe_r  <= strobe_nxt;
    end
  end

  // result payload and walk index
  always_ff @(posedge clk) begin
    wb_idx_r <= wb_idx_nxt;
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    handle_r <= handle_nxt;
    pend_r   <= pend_nxt;
    last_r   <= last_nxt;
  end

  // slot memory: handle, counter and reload period
  ptss_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign out_strobe      = strobe_r;
  assign out_slot_number = slot_r;
  assign out_status      = status_r;
  assign out_handle_out  = handle_r;
  assign out_pending_out = pend_r;
  assign out_last        = last_r;

  // a free slot never holds a pending flag
  `PTSS_ASSERT_IMPL(a_pend_valid, clk, rst_n, 1'b1, (pending_r & ~valid_r) == '0)
  // a tick transfer always starts a walk
  `PTSS_ASSERT_NEXT(a_tick_busy, clk, rst_n,
                    accept && (in_req_type == REQ_TICK), state_r == ST_TICK)
  // a nothing-pending answer means no flag is set
  `PTSS_ASSERT_IMPL(a_empty_none, clk, rst_n,
                    strobe_r && (status_r == STAT_EMPTY), pending_r == '0)
  // results that are not last only come out of a dispatch walk
  `PTSS_ASSERT_IMPL(a_notlast_disp, clk, rst_n, strobe_r && !last_r, state_r == ST_DISP)

endmodule

`default_nettype wire

### sim/tb_periodic_task_slot_scheduler.sv
// ---------------------------------------------------------------------------
// tb_periodic_task_slot_scheduler
// self-checking bench for the periodic task slot scheduler: a directed
// opening run (empty table, bad indexes, unknown codes, filling the table,
// firing and dispatch) is followed by random request mixes sent in bursts.
// A behavioural copy of the slot table predicts every result, and the
// monitor compares each strobed result against the oldest prediction.
// ---------------------------------------------------------------------------
module tb_periodic_task_slot_scheduler
  import ptss_pkg::*;
;

  localparam int          NUM_SLOTS        = 8;
  localparam int          COUNT_BITS       = 16;
  localparam logic [3:0]  SLOT_NONE        = 4'(NUM_SLOTS);
  localparam logic [2:0]  REQ_FIRST_UNUSED = 3'(REQ_QUERY) + 3'd1;
  localparam logic [2:0]  REQ_LAST_CODE    = 3'h7;
  localparam int          RANDOM_REQS      = 146;
  localparam int          DRAIN_LIMIT      = 2000;

  typedef struct {
    logic [2:0]  kind;
    logic [7:0]  handle;
    logic [15:0] delay;
    logic [15:0] period;
    logic [3:0]  slot_sel;
    bit          wait_idle;
  } sched_req_t;

  typedef struct packed {
    logic [3:0] slot;
    status_t    status;
    logic [7:0] handle;
    logic       pending;
    logic       last;
  } sched_answer_t;

  // dut connections
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_task_handle = '0;
  logic [15:0] in_first_delay = '0;
  logic [15:0] in_reload_period = '0;
  logic [3:0]  in_slot_index = '0;
  logic        out_strobe;
  logic [3:0]  out_slot_number;
  logic [1:0]  out_status;
  logic [7:0]  out_handle_out;
  logic        out_pending_out;
  logic        out_last;

  // shadow slot table
  bit                    slot_used [NUM_SLOTS];
  logic [7:0]            slot_tag [NUM_SLOTS];
  logic [COUNT_BITS-1:0] slot_count [NUM_SLOTS];
  logic [COUNT_BITS-1:0] slot_period [NUM_SLOTS];
  bit                    slot_due [NUM_SLOTS];

  sched_req_t    requests_q [$];
  sched_answer_t answers_due [$];

  bit took;
  int burst_left = 1;
  int gap_left = 0;
  int errors = 0;
  int n_taken = 0;
  int n_ticks = 0;
  int n_dispatched = 0;
  int n_full = 0;
  int n_bad = 0;

  periodic_task_slot_scheduler #(
    .NUM_SLOTS  (NUM_SLOTS),
    .COUNT_BITS (COUNT_BITS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_req_type      (in_req_type),
    .in_task_handle   (in_task_handle),
    .in_first_delay   (in_first_delay),
    .in_reload_period (in_reload_period),
    .in_slot_index    (in_slot_index),
    .out_strobe       (out_strobe),
    .out_slot_number  (out_slot_number),
    .out_status       (out_status),
    .out_handle_out   (out_handle_out),
    .out_pending_out  (out_pending_out),
    .out_last         (out_last)
  );

  always #4 clk = ~clk;

  function automatic void push_req(logic [2:0] kind, logic [7:0] handle, logic [15:0] delay,
                                   logic [15:0] period, logic [3:0] slot_sel, bit wait_idle);
    sched_req_t r;
    r = '{kind, handle, delay, period, slot_sel, wait_idle};
    requests_q.push_back(r);
  endfunction

  function automatic void push_answer(logic [3:0] slot, status_t status, logic [7:0] handle,
                                      logic pending, logic last);
    sched_answer_t a;
    a = '{slot, status, handle, pending, last};
    answers_due.push_back(a);
  endfunction

  // counter value: mostly short so slots fire often, sometimes full range
  function automatic logic [15:0] pick_count();
    if ($urandom_range(0, 9) == 0) begin
      return 16'($urandom);
    end
    return 16'($urandom_range(0, 6));
  endfunction

  // random request; every field is randomised whatever the kind
  function automatic void push_random_req();
    int         roll;
    logic [2:0] kind;
    logic [3:0] sel;
    roll = $urandom_range(0, 99);
    if (roll < 33)      kind = REQ_TICK;
    else if (roll < 52) kind = REQ_ADD;
    else if (roll < 65) kind = REQ_DELETE;
    else if (roll < 80) kind = REQ_DISPATCH;
    else if (roll < 93) kind = REQ_QUERY;
    else                kind = 3'($urandom_range(REQ_FIRST_UNUSED, REQ_LAST_CODE));
    sel = ($urandom_range(0, 5) == 0) ? 4'($urandom) : 4'($urandom_range(0, NUM_SLOTS - 1));
    push_req(kind, 8'($urandom), pick_count(), pick_count(), sel, $urandom_range(0, 39) == 0);
  endfunction

  // predict the results of one transferred request and update the table
  task automatic apply_request(input sched_req_t r);
    int i;
    bit hit;
    hit = 1'b0;
    unique case (r.kind)
      REQ_TICK: begin
        n_ticks++;
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i]) begin
            if (slot_count[i] != 0) slot_count[i]--;
            if (slot_count[i] == 0) begin
              slot_due[i]   = 1'b1;
              slot_count[i] = slot_period[i];
            end
          end
        end
        push_answer(SLOT_NONE, STAT_OK, 8'h00, 1'b0, 1'b1);
      end
      REQ_ADD: begin
        for (i = 0; i < NUM_SLOTS && !hit; i++) begin
          if (!slot_used[i]) begin
            hit            = 1'b1;
            slot_used[i]   = 1'b1;
            slot_tag[i]    = r.handle;
            slot_count[i]  = r.delay[COUNT_BITS-1:0];
            slot_period[i] = r.period[COUNT_BITS-1:0];
            slot_due[i]    = 1'b0;
            push_answer(4'(i), STAT_OK, 8'h00, 1'b0, 1'b1);
          end
        end
        if (!hit) begin
          n_full++;
          push_answer(SLOT_NONE, STAT_FULL, 8'h00, 1'b0, 1'b1);
        end
      end
      REQ_DELETE, REQ_QUERY: begin
        if (r.slot_sel >= NUM_SLOTS) begin
          n_bad++;
          push_answer(SLOT_NONE, STAT_BAD, 8'h00, 1'b0, 1'b1);
        end else if (r.kind == REQ_QUERY) begin
          push_answer(r.slot_sel, STAT_OK, 8'h00, slot_due[r.slot_sel], 1'b1);
        end else begin
          slot_used[r.slot_sel]   = 1'b0;
          slot_tag[r.slot_sel]    = '0;
          slot_count[r.slot_sel]  = '0;
          slot_period[r.slot_sel] = '0;
          slot_due[r.slot_sel]    = 1'b0;
          push_answer(r.slot_sel, STAT_OK, 8'h00, 1'b0, 1'b1);
        end
      end
      REQ_DISPATCH: begin
        for (i = 0; i < NUM_SLOTS; i++) begin
          if (slot_due[i]) begin
            hit         = 1'b1;
            slot_due[i] = 1'b0;
            n_dispatched++;
            push_answer(4'(i), STAT_OK, slot_tag[i], 1'b0, 1'b0);
          end
        end
        if (hit) answers_due[answers_due.size() - 1].last = 1'b1;
        else     push_answer(SLOT_NONE, STAT_EMPTY, 8'h00, 1'b0, 1'b1);
      end
      default: begin
        push_answer(SLOT_NONE, STAT_OK, 8'h00, 1'b0, 1'b1);
      end
    endcase
  endtask

  // monitor: check strobed results, then record a request transfer
  always @(posedge clk) begin
    sched_req_t    r;
    sched_answer_t got;
    sched_answer_t want;
    if (out_strobe === 1'b1) begin
      got = '{out_slot_number, status_t'(out_status), out_handle_out, out_pending_out, out_last};
      if (answers_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: slot %0d status %0d handle %02h pending %0b last %0b",
                 $time, got.slot, got.status, got.handle, got.pending, got.last);
      end else begin
        want = answers_due.pop_front();
        if (got !== want) begin
          errors++;
          $display({"%0t: result mismatch: expected slot %0d status %0d handle %02h ",
                    "pending %0b last %0b, got slot %0d status %0d handle %02h pending %0b ",
                    "last %0b"}, $time, want.slot, want.status, want.handle, want.pending,
                   want.last, got.slot, got.status, got.handle, got.pending, got.last);
        end
      end
    end
    if (rst_n && start && busy === 1'b0) begin
      r = '{in_req_type, in_task_handle, in_first_delay, in_reload_period, in_slot_index, 1'b0};
      apply_request(r);
      n_taken++;
      took = 1'b1;
    end
  end

  // driver: bursts of requests with random gaps, changing at the falling edge
  always @(negedge clk) begin
    sched_req_t r;
    if (!rst_n) begin
      start <= 1'b0;
      took = 1'b0;
    end else if (!start || took) begin
      took = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (requests_q.size() == 0) begin
        start <= 1'b0;
      end else if (requests_q[0].wait_idle && answers_due.size() != 0) begin
        // hold off until the block has answered everything
        start <= 1'b0;
      end else begin
        r = requests_q.pop_front();
        in_req_type      <= r.kind;
        in_task_handle   <= r.handle;
        in_first_delay   <= r.delay;
        in_reload_period <= r.period;
        in_slot_index    <= r.slot_sel;
        start            <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    int i;
    int spin;
    // empty table, bad indexes and unknown codes
    push_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_QUERY, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_QUERY, 8'h00, 16'h0000, 16'h0000, 4'hf, 1'b0);
    push_req(REQ_DELETE, 8'h00, 16'h0000, 16'h0000, SLOT_NONE, 1'b0);
    push_req(REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd3, 1'b0);
    for (i = REQ_FIRST_UNUSED; i <= REQ_LAST_CODE; i++) begin
      push_req(3'(i), 8'hff, 16'hffff, 16'hffff, 4'hf, 1'b0);
    end
    // fill the table: period zero, longest counters, then short ones
    push_req(REQ_ADD, 8'hff, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_ADD, 8'h00, 16'hffff, 16'hffff, 4'd0, 1'b0);
    push_req(REQ_ADD, 8'ha5, 16'h0001, 16'h0002, 4'd0, 1'b0);
    push_req(REQ_ADD, 8'h5a, 16'h0002, 16'h0000, 4'd0, 1'b0);
    for (i = 4; i < NUM_SLOTS; i++) begin
      push_req(REQ_ADD, 8'(8'h10 + i), 16'(i - 3), 16'h0001, 4'd0, 1'b0);
    end
    // full table, firing, dispatch and slot reuse
    push_req(REQ_ADD, 8'h77, 16'h0003, 16'h0003, 4'd0, 1'b0);
    push_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_TICK, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_QUERY, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_DISPATCH, 8'h00, 16'h0000, 16'h0000, 4'd0, 1'b0);
    push_req(REQ_DELETE, 8'h00, 16'h0000, 16'h0000, 4'd1, 1'b1);
    push_req(REQ_ADD, 8'h3c, 16'h0000, 16'h0004, 4'd0, 1'b0);
    for (i = 0; i < RANDOM_REQS; i++) push_random_req();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (requests_q.size() != 0 || start) @(posedge clk);
    for (spin = 0; spin < DRAIN_LIMIT && answers_due.size() != 0; spin++) @(posedge clk);
    repeat (NUM_SLOTS + 4) @(posedge clk);
    if (answers_due.size() != 0) begin
      errors += answers_due.size();
      $display("%0t: %0d expected results never arrived", $time, answers_due.size());
    end

    $display("run covered %0d requests: %0d ticks, %0d slots dispatched", n_taken, n_ticks,
             n_dispatched);
    $display("add on full table %0d times, bad slot index %0d times, %0d mismatches", n_full,
             n_bad, errors);
    if (errors == 0) begin
      $display("tb_periodic_task_slot_scheduler OK");
    end else begin
      $display("tb_periodic_task_slot_scheduler NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3000000;
    $display("tb_periodic_task_slot_scheduler NOT OK");
    $finish;
  end

endmodule
